FILE: rtl/core/hvd_pkg.sv
// Shared constants, tables and widths for the haversine distance unit.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hvd_pkg;

    // Field formats
    localparam int ANGLE_FRAC_BITS = 22;
    localparam int DIST_FRAC_BITS  = 4;
    localparam int LON_W           = 31;
    localparam int LAT_W           = 30;
    localparam int DIST_W          = 30;
    localparam int RADIUS_W        = 24;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

    // APB register map
    localparam int   CFG_DATA_W        = 32;
    localparam int   CFG_ADDR_W        = 3;
    localparam int   CFG_IDX_LSB       = 2;
    localparam logic REG_SPHERE_RADIUS = 1'b0;

    // Degrees to phase (2^-32 turn). Latitudes enter doubled, so both kinds
    // use q = floor(((|v| << TP_SHIFT) + TP_BIAS) / TP_DIV).
    localparam int PHASE_W   = 32;
    localparam int TP_SHIFT  = 31 - ANGLE_FRAC_BITS - 2;
    localparam int TP_DIV    = 90;
    localparam int TP_BIAS   = TP_DIV / 2;
    localparam int TP_X_W    = 38;
    localparam int TP_SPLIT  = TP_X_W / 2;
    localparam int TP_RCP_W  = 32;
    localparam logic [TP_RCP_W-1:0] TP_RECIP = 32'd3054198966; // floor(2^38 / 90)
    localparam int TP_LAT    = 4;

    // CORDIC
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] Q30_ONE   = CORDIC_W'(64'd1 << 30);
    localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(64'd1 << 31);
    localparam logic signed [CORDIC_W-1:0] CORDIC_KINV = CORDIC_W'(64'd652032874);
    localparam int SC_LAT = CORDIC_ITERS + 1;
    localparam int AT_LAT = CORDIC_ITERS;

    localparam logic [31:0] ATAN_PHASE [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // Square root, one result bit per stage
    localparam int SQ_ROOT_W = 31;
    localparam int SQ_DIGITS = SQ_ROOT_W;
    localparam int SQ_RAD_W  = 2 * SQ_DIGITS;
    localparam int SQ_REM_W  = SQ_ROOT_W + 3;
    localparam int SQ_LAT    = SQ_DIGITS;

    // Central angle to metres
    localparam int P_W = 32;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam int PROD_LAT = 3;

    // Stages from the input register up to the angle CORDIC output
    localparam int MID_LAT = TP_LAT + SC_LAT + PROD_LAT + SQ_LAT + AT_LAT;
    localparam int CLP_LAT = SQ_LAT + AT_LAT;

endpackage

`default_nettype wire

FILE: rtl/core/hvd_if.sv
// Stream channels of the haversine distance unit: coordinate items in,
// distance items out. Depends on hvd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hvd_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [hvd_pkg::LON_W-1:0]  lon_a;
    logic signed [hvd_pkg::LAT_W-1:0]  lat_a;
    logic signed [hvd_pkg::LON_W-1:0]  lon_b;
    logic signed [hvd_pkg::LAT_W-1:0]  lat_b;

    modport source (output valid, lon_a, lat_a, lon_b, lat_b, input ready);
    modport sink   (input valid, lon_a, lat_a, lon_b, lat_b, output ready);
endinterface

interface hvd_out_if;
    logic                         valid;
    logic                         ready;
    logic [hvd_pkg::DIST_W-1:0]   distance;
    logic                         clamped;

    modport source (output valid, distance, clamped, input ready);
    modport sink   (input valid, distance, clamped, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hvd_to_phase.sv
// Fixed-point degrees to phase (2^-32 turn), rounded half away from zero.
// Division by 90 by reciprocal multiply in two halves; depends on hvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hvd_to_phase (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [hvd_pkg::PHASE_W-1:0]  i_value,
    output logic signed [hvd_pkg::PHASE_W-1:0]  o_phase
);

    localparam int XW = hvd_pkg::TP_X_W;
    localparam int SP = hvd_pkg::TP_SPLIT;
    localparam int PW = SP + hvd_pkg::TP_RCP_W;
    localparam int SW = PW + SP + 1;

    logic [hvd_pkg::PHASE_W-1:0] w_mag;
    logic [XW-1:0]               w_x;
    logic [XW-1:0]               r1_x;
    logic                        r1_neg;
    logic [PW-1:0]               r2_ph;
    logic [PW-1:0]               r2_pl;
    logic [7:0]                  r2_xlo;
    logic                        r2_neg;
    logic [SW-1:0]               w_sum;
    logic [hvd_pkg::PHASE_W-1:0] r3_q0;
    logic [7:0]                  r3_xlo;
    logic                        r3_neg;
    logic [7:0]                  w_rem;
    logic [hvd_pkg::PHASE_W-1:0] w_q;

    always_comb begin
        w_mag = i_value[hvd_pkg::PHASE_W-1] ? hvd_pkg::PHASE_W'(-i_value)
                                             : hvd_pkg::PHASE_W'(i_value);
        w_x   = (XW'(w_mag) << hvd_pkg::TP_SHIFT) + XW'(hvd_pkg::TP_BIAS);
    end

    // q0 is at most one below the true quotient
    assign w_sum = (SW'(r2_ph) << SP) + SW'(r2_pl);

    // only the low byte of x - 90*q0 matters, the true remainder is below 180
    always_comb begin
        w_rem = 8'(r3_xlo - 8'(r3_q0[7:0] * 8'(hvd_pkg::TP_DIV)));
        w_q   = r3_q0 + hvd_pkg::PHASE_W'(w_rem >= 8'(hvd_pkg::TP_DIV));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x    <= w_x;
            r1_neg  <= i_value[hvd_pkg::PHASE_W-1];
            r2_ph   <= PW'(r1_x[XW-1:SP]) * PW'(hvd_pkg::TP_RECIP);
            r2_pl   <= PW'(r1_x[SP-1:0]) * PW'(hvd_pkg::TP_RECIP);
            r2_xlo  <= r1_x[7:0];
            r2_neg  <= r1_neg;
            r3_q0   <= w_sum[XW +: hvd_pkg::PHASE_W];
            r3_xlo  <= r2_xlo;
            r3_neg  <= r2_neg;
            o_phase <= r3_neg ? $signed(-w_q) : $signed(w_q);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hvd_sincos.sv
// Pipelined rotation CORDIC, one iteration per stage, sine and cosine in Q30.
// Uses the arctangent table and widths of hvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hvd_sincos (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [hvd_pkg::PHASE_W-1:0]   i_phase,
    output logic signed [hvd_pkg::CORDIC_W-1:0]  o_sin,
    output logic signed [hvd_pkg::CORDIC_W-1:0]  o_cos
);

    localparam int CW = hvd_pkg::CORDIC_W;
    localparam int N  = hvd_pkg::CORDIC_ITERS;

    logic signed [CW-1:0] w_z0;
    logic                 w_flip0;
    logic signed [CW-1:0] w_px [N];
    logic signed [CW-1:0] w_py [N];
    logic signed [CW-1:0] w_pz [N];
    logic                 w_pf [N];
    logic signed [CW-1:0] r_x  [N];
    logic signed [CW-1:0] r_y  [N];
    logic signed [CW-1:0] r_z  [N];
    logic                 r_flip [N];

    // fold phases beyond +-90 degrees by a half turn, negate at the end
    always_comb begin
        w_z0    = CW'(i_phase);
        w_flip0 = 1'b0;
        if (w_z0 > hvd_pkg::Q30_ONE) begin
            w_z0    = w_z0 - hvd_pkg::HALF_TURN;
            w_flip0 = 1'b1;
        end else if (w_z0 < -hvd_pkg::Q30_ONE) begin
            w_z0    = w_z0 + hvd_pkg::HALF_TURN;
            w_flip0 = 1'b1;
        end
    end

    for (genvar gi = 0; gi < N; gi++) begin : g_stage
        localparam logic signed [CW-1:0] C_AT = $signed(CW'(hvd_pkg::ATAN_PHASE[gi]));
        if (gi == 0) begin : g_first
            assign w_px[gi] = hvd_pkg::CORDIC_KINV;
            assign w_py[gi] = '0;
            assign w_pz[gi] = w_z0;
            assign w_pf[gi] = w_flip0;
        end else begin : g_next
            assign w_px[gi] = r_x[gi-1];
            assign w_py[gi] = r_y[gi-1];
            assign w_pz[gi] = r_z[gi-1];
            assign w_pf[gi] = r_flip[gi-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_pz[gi][CW-1]) begin
                    r_x[gi] <= w_px[gi] - (w_py[gi] >>> gi);
                    r_y[gi] <= w_py[gi] + (w_px[gi] >>> gi);
                    r_z[gi] <= w_pz[gi] - C_AT;
                end else begin
                    r_x[gi] <= w_px[gi] + (w_py[gi] >>> gi);
                    r_y[gi] <= w_py[gi] - (w_px[gi] >>> gi);
                    r_z[gi] <= w_pz[gi] + C_AT;
                end
                r_flip[gi] <= w_pf[gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= r_flip[N-1] ? -r_y[N-1] : r_y[N-1];
            o_cos <= r_flip[N-1] ? -r_x[N-1] : r_x[N-1];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hvd_sqrt.sv
// Pipelined integer square root, one root bit per stage (restoring method).
// Widths come from hvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hvd_sqrt (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [hvd_pkg::SQ_RAD_W-1:0]      i_rad,
    output logic [hvd_pkg::SQ_ROOT_W-1:0]     o_root
);

    localparam int N  = hvd_pkg::SQ_DIGITS;
    localparam int RW = hvd_pkg::SQ_REM_W;
    localparam int QW = hvd_pkg::SQ_ROOT_W;
    localparam int AW = hvd_pkg::SQ_RAD_W;

    logic [RW-1:0] w_prem  [N];
    logic [QW-1:0] w_proot [N];
    logic [AW-1:0] w_prad  [N];
    logic [RW-1:0] r_rem   [N];
    logic [QW-1:0] r_root  [N];
    logic [AW-1:0] r_rad   [N];

    for (genvar gk = 0; gk < N; gk++) begin : g_digit
        logic [RW+1:0] w_cur;
        logic [RW+1:0] w_trial;
        logic          w_ge;
        if (gk == 0) begin : g_first
            assign w_prem[gk]  = '0;
            assign w_proot[gk] = '0;
            assign w_prad[gk]  = i_rad;
        end else begin : g_next
            assign w_prem[gk]  = r_rem[gk-1];
            assign w_proot[gk] = r_root[gk-1];
            assign w_prad[gk]  = r_rad[gk-1];
        end
        always_comb begin
            w_cur   = {w_prem[gk], w_prad[gk][AW-1 -: 2]};
            w_trial = (RW+2)'({w_proot[gk], 2'b01});
            w_ge    = (w_cur >= w_trial);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gk]  <= w_ge ? RW'(w_cur - w_trial) : RW'(w_cur);
                r_root[gk] <= {w_proot[gk][QW-2:0], w_ge};
                r_rad[gk]  <= w_prad[gk] << 2;
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

`default_nettype wire

FILE: rtl/core/hvd_atan2.sv
// Pipelined vectoring CORDIC: angle of (x, y), x and y non-negative, in phase
// units. One iteration per stage; table and widths from hvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hvd_atan2 (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [hvd_pkg::SQ_ROOT_W-1:0]        i_x,
    input  logic [hvd_pkg::SQ_ROOT_W-1:0]        i_y,
    output logic signed [hvd_pkg::CORDIC_W-1:0]  o_angle
);

    localparam int CW = hvd_pkg::CORDIC_W;
    localparam int N  = hvd_pkg::CORDIC_ITERS;

    logic signed [CW-1:0] w_px [N];
    logic signed [CW-1:0] w_py [N];
    logic signed [CW-1:0] w_pz [N];
    logic signed [CW-1:0] r_x  [N];
    logic signed [CW-1:0] r_y  [N];
    logic signed [CW-1:0] r_z  [N];

    for (genvar gi = 0; gi < N; gi++) begin : g_stage
        localparam logic signed [CW-1:0] C_AT = $signed(CW'(hvd_pkg::ATAN_PHASE[gi]));
        if (gi == 0) begin : g_first
            assign w_px[gi] = $signed(CW'(i_x));
            assign w_py[gi] = $signed(CW'(i_y));
            assign w_pz[gi] = '0;
        end else begin : g_next
            assign w_px[gi] = r_x[gi-1];
            assign w_py[gi] = r_y[gi-1];
            assign w_pz[gi] = r_z[gi-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_py[gi][CW-1]) begin
                    r_x[gi] <= w_px[gi] + (w_py[gi] >>> gi);
                    r_y[gi] <= w_py[gi] - (w_px[gi] >>> gi);
                    r_z[gi] <= w_pz[gi] + C_AT;
                end else begin
                    r_x[gi] <= w_px[gi] - (w_py[gi] >>> gi);
                    r_y[gi] <= w_py[gi] + (w_px[gi] >>> gi);
                    r_z[gi] <= w_pz[gi] - C_AT;
                end
            end
        end
    end

    assign o_angle = r_z[N-1];

endmodule

`default_nettype wire

FILE: rtl/core/haversine_distance_unit.sv
// Haversine great-circle distance unit, top level: input stage, phase
// conversion, sine/cosine, haversine products, square roots, angle, scaling.
// Depends on hvd_pkg, hvd_if and the hvd_* pipeline modules.
//
//   channel   dir  handshake         payload
//   i_in      in   valid/ready       lon_a, lat_a, lon_b, lat_b
//   o_out     out  valid/ready       distance, clamped
//   APB       in   psel/penable      sphere_radius_m at byte address 0
//
// One item per cycle unless the output queue is full and not drained; the pipeline
// depth is set by the 30-stage CORDICs and the 31-stage square roots.
// Reset (i_rst_n low, synchronous) empties the pipeline and the output queue
// and loads the radius of 6371000 m. The whole pipeline holds when the
// two-entry output queue is full and not being drained, so items still enter
// while one result waits.
`timescale 1ns / 1ps
`default_nettype none

module haversine_distance_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    hvd_in_if.sink                               i_in,
    hvd_out_if.source                            o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hvd_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [hvd_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [hvd_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int PW  = hvd_pkg::PHASE_W;
    localparam int CW  = hvd_pkg::CORDIC_W;
    localparam int QW  = hvd_pkg::SQ_ROOT_W;
    localparam int DW  = hvd_pkg::DIST_W;
    localparam int RW  = hvd_pkg::RADIUS_W;
    localparam int ML  = hvd_pkg::MID_LAT;
    localparam int CL  = hvd_pkg::CLP_LAT;
    localparam int FW  = RW + hvd_pkg::P_W;
    localparam logic [1:0] Q_FULL = 2'd2;

    // ---------------- configuration ----------------
    logic [RW-1:0] r_radius;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[hvd_pkg::CFG_ADDR_W-1:hvd_pkg::CFG_IDX_LSB] ==
                       hvd_pkg::REG_SPHERE_RADIUS);
    assign prdata   = (paddr[hvd_pkg::CFG_ADDR_W-1:hvd_pkg::CFG_IDX_LSB] ==
                       hvd_pkg::REG_SPHERE_RADIUS) ? hvd_pkg::CFG_DATA_W'(r_radius) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= hvd_pkg::RADIUS_RESET;
        end else if (w_cfg_wr) begin
            r_radius <= pwdata[RW-1:0];
        end
    end

    // ---------------- flow control ----------------
    logic [1:0] r_cnt;
    logic       w_pop;
    logic       w_en;

    assign w_pop      = (r_cnt != 2'd0) && o_out.ready;
    assign w_en       = (r_cnt != Q_FULL) || w_pop;
    assign i_in.ready = w_en;

    // ---------------- input stage ----------------
    logic signed [PW-1:0] r0_lat_a2;
    logic signed [PW-1:0] r0_lat_b2;
    logic signed [PW-1:0] r0_dlon;
    logic signed [PW-1:0] r0_dlat;
    logic                 r0_zero;
    logic                 r0_vld;
    logic signed [PW-1:0] w_dlon;
    logic signed [PW-1:0] w_dlat;

    assign w_dlon = PW'(i_in.lon_b) - PW'(i_in.lon_a);
    assign w_dlat = PW'(i_in.lat_b) - PW'(i_in.lat_a);

    // latitudes doubled: full-angle conversion equals half-angle of twice the value
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_lat_a2 <= PW'(i_in.lat_a) <<< 1;
            r0_lat_b2 <= PW'(i_in.lat_b) <<< 1;
            r0_dlon   <= w_dlon;
            r0_dlat   <= w_dlat;
            r0_zero   <= (w_dlon == '0) && (w_dlat == '0);
        end
    end

    // ---------------- phase and trig ----------------
    logic signed [PW-1:0] w_ph_la, w_ph_lb, w_ph_dlon, w_ph_dlat;
    logic signed [CW-1:0] w_c1, w_c2, w_s1, w_s2;

    hvd_to_phase u_tp_la   (.i_clk(i_clk), .i_en(w_en), .i_value(r0_lat_a2), .o_phase(w_ph_la));
    hvd_to_phase u_tp_lb   (.i_clk(i_clk), .i_en(w_en), .i_value(r0_lat_b2), .o_phase(w_ph_lb));
    hvd_to_phase u_tp_dlon (.i_clk(i_clk), .i_en(w_en), .i_value(r0_dlon), .o_phase(w_ph_dlon));
    hvd_to_phase u_tp_dlat (.i_clk(i_clk), .i_en(w_en), .i_value(r0_dlat), .o_phase(w_ph_dlat));

    hvd_sincos u_sc_la   (.i_clk(i_clk), .i_en(w_en), .i_phase(w_ph_la),
                          .o_sin(), .o_cos(w_c1));
    hvd_sincos u_sc_lb   (.i_clk(i_clk), .i_en(w_en), .i_phase(w_ph_lb),
                          .o_sin(), .o_cos(w_c2));
    hvd_sincos u_sc_dlon (.i_clk(i_clk), .i_en(w_en), .i_phase(w_ph_dlon),
                          .o_sin(w_s1), .o_cos());
    hvd_sincos u_sc_dlat (.i_clk(i_clk), .i_en(w_en), .i_phase(w_ph_dlat),
                          .o_sin(w_s2), .o_cos());

    // ---------------- haversine term ----------------
    logic signed [31:0] w_s1n, w_s2n, w_c1n, w_c2n;
    logic signed [63:0] w_s1sq, w_s2sq, w_cc, w_t;
    logic signed [31:0] r1_s1sq, r1_s2sq, r1_cc;
    logic signed [CW-1:0] r2_t, r2_s2sq;
    logic signed [CW-1:0] w_h, w_hcomp_raw;
    logic [QW-1:0]      r3_hc, r3_hcomp;
    logic               r3_clp;
    logic               w_over;

    assign w_s1n  = 32'(w_s1);
    assign w_s2n  = 32'(w_s2);
    assign w_c1n  = 32'(w_c1);
    assign w_c2n  = 32'(w_c2);
    assign w_s1sq = 64'(w_s1n) * 64'(w_s1n);
    assign w_s2sq = 64'(w_s2n) * 64'(w_s2n);
    assign w_cc   = 64'(w_c1n) * 64'(w_c2n);
    assign w_t    = 64'(r1_cc) * 64'(r1_s1sq);

    assign w_h         = r2_s2sq + r2_t;
    assign w_hcomp_raw = hvd_pkg::Q30_ONE - r2_s2sq - r2_t;
    assign w_over      = (w_h > hvd_pkg::Q30_ONE);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_s1sq <= 32'(w_s1sq >>> 30);
            r1_s2sq <= 32'(w_s2sq >>> 30);
            r1_cc   <= 32'(w_cc >>> 30);
            r2_t    <= CW'(w_t >>> 30);
            r2_s2sq <= CW'(r1_s2sq);
            r3_clp  <= w_over;
            // negative h only from latitudes past the poles: taken as zero
            if (w_h[CW-1]) begin
                r3_hc    <= '0;
                r3_hcomp <= QW'(hvd_pkg::Q30_ONE);
            end else begin
                r3_hc    <= QW'(w_h);
                r3_hcomp <= QW'(w_hcomp_raw);
            end
        end
    end

    // ---------------- square roots and angle ----------------
    logic [QW-1:0]        w_sy, w_sx;
    logic signed [CW-1:0] w_z;

    hvd_sqrt u_sq_y (.i_clk(i_clk), .i_en(w_en),
                     .i_rad(hvd_pkg::SQ_RAD_W'(r3_hc) << 30), .o_root(w_sy));
    hvd_sqrt u_sq_x (.i_clk(i_clk), .i_en(w_en),
                     .i_rad(hvd_pkg::SQ_RAD_W'(r3_hcomp) << 30), .o_root(w_sx));

    hvd_atan2 u_at (.i_clk(i_clk), .i_en(w_en), .i_x(w_sx), .i_y(w_sy), .o_angle(w_z));

    // ---------------- sideband delay lines ----------------
    logic r_vld_d  [ML];
    logic r_zero_d [ML];
    logic r_clp_d  [CL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            for (int k = 0; k < ML; k++) begin
                r_vld_d[k] <= 1'b0;
            end
        end else if (w_en) begin
            r0_vld     <= i_in.valid;
            r_vld_d[0] <= r0_vld;
            for (int k = 1; k < ML; k++) begin
                r_vld_d[k] <= r_vld_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero_d[0] <= r0_zero;
            for (int k = 1; k < ML; k++) begin
                r_zero_d[k] <= r_zero_d[k-1];
            end
            r_clp_d[0] <= r3_clp;
            for (int k = 1; k < CL; k++) begin
                r_clp_d[k] <= r_clp_d[k-1];
            end
        end
    end

    // ---------------- angle to distance ----------------
    logic [hvd_pkg::P_W-1:0] r_f1_p, r_f2_radq;
    logic [FW-1:0]           r_f3_prod;
    logic                    r_f1_vld, r_f2_vld, r_f3_vld;
    logic                    r_f1_zero, r_f2_zero, r_f3_zero;
    logic                    r_f1_clp, r_f2_clp, r_f3_clp;
    logic [hvd_pkg::P_W-2:0] w_zc;
    logic [63:0]             w_radq_full;
    logic [FW:0]             w_round;
    logic [DW-1:0]           w_dist;

    always_comb begin
        if (w_z[CW-1]) begin
            w_zc = '0;
        end else if (w_z > hvd_pkg::Q30_ONE) begin
            w_zc = (hvd_pkg::P_W-1)'(hvd_pkg::Q30_ONE);
        end else begin
            w_zc = (hvd_pkg::P_W-1)'(w_z);
        end
    end

    assign w_radq_full = 64'(r_f1_p) * 64'(hvd_pkg::TWO_PI_Q30);
    assign w_round = (FW+1)'(r_f3_prod) +
                     ((FW+1)'(1) << (29 - hvd_pkg::DIST_FRAC_BITS));
    assign w_dist  = r_f3_zero ? '0 : DW'(w_round >> (30 - hvd_pkg::DIST_FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_p    <= r_clp_d[CL-1] ? hvd_pkg::P_W'(hvd_pkg::HALF_TURN) : {w_zc, 1'b0};
            r_f1_zero <= r_zero_d[ML-1];
            r_f1_clp  <= r_clp_d[CL-1];
            r_f2_radq <= w_radq_full[63:32];
            r_f2_zero <= r_f1_zero;
            r_f2_clp  <= r_f1_clp;
            r_f3_prod <= FW'(r_radius) * FW'(r_f2_radq);
            r_f3_zero <= r_f2_zero;
            r_f3_clp  <= r_f2_clp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= r_vld_d[ML-1];
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
        end
    end

    // ---------------- output queue, two entries ----------------
    logic          w_push;
    logic [DW-1:0] r_q0_dist, r_q1_dist;
    logic          r_q0_clp, r_q1_clp;
    logic          w_clp_out;

    assign w_push    = w_en && r_f3_vld;
    assign w_clp_out = r_f3_clp && !r_f3_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (w_pop && (r_cnt == Q_FULL)) begin
            r_q0_dist <= r_q1_dist;
            r_q0_clp  <= r_q1_clp;
            if (w_push) begin
                r_q1_dist <= w_dist;
                r_q1_clp  <= w_clp_out;
            end
        end else if (w_push && ((r_cnt == 2'd0) || w_pop)) begin
            r_q0_dist <= w_dist;
            r_q0_clp  <= w_clp_out;
        end else if (w_push) begin
            r_q1_dist <= w_dist;
            r_q1_clp  <= w_clp_out;
        end else begin
            // queue contents hold
        end
    end

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.distance = r_q0_dist;
    assign o_out.clamped  = r_q0_clp;

endmodule

`default_nettype wire

FILE: rtl/core/hvd_checker.sv
// Port-level checks for haversine_distance_unit, attached by bind.
// Depends on hvd_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module hvd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [hvd_pkg::DIST_W-1:0]       i_distance,
    input logic                             i_clamped,
    input logic                             i_psel,
    input logic                             i_penable,
    input logic                             i_pwrite,
    input logic [hvd_pkg::CFG_ADDR_W-1:0]   i_paddr,
    input logic [hvd_pkg::CFG_DATA_W-1:0]   i_pwdata,
    input logic [hvd_pkg::CFG_DATA_W-1:0]   i_prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_distance) && $stable(i_clamped))
        else $error("output item changed while stalled");

    // input back-pressure only ever comes from a full output queue
    a_ready_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no output item pending");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output item present right after reset");

    a_radius_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite &&
        (i_paddr[hvd_pkg::CFG_ADDR_W-1:hvd_pkg::CFG_IDX_LSB] == hvd_pkg::REG_SPHERE_RADIUS)
        ##1 (i_paddr[hvd_pkg::CFG_ADDR_W-1:hvd_pkg::CFG_IDX_LSB] ==
             hvd_pkg::REG_SPHERE_RADIUS)
        |-> i_prdata == hvd_pkg::CFG_DATA_W'($past(i_pwdata[hvd_pkg::RADIUS_W-1:0])))
        else $error("radius register does not read back the written value");

endmodule

bind haversine_distance_unit hvd_checker u_hvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_distance  (o_out.distance),
    .i_clamped   (o_out.clamped),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

`default_nettype wire
